// ===== rtl/pli_pkg.sv =====
// Shared types, constants and helpers of the piecewise linear interpolator.
`timescale 1ns / 1ps

package pli_pkg;

   localparam int MAX_KNOTS = 16;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W     = $clog2(MAX_KNOTS);
   localparam int CNT_W     = $clog2(MAX_KNOTS + 1);
   localparam int DATA_W    = 32;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int PROD_W    = 2 * DIFF_W;
   localparam int HALF_W    = (DIFF_W + 1) / 2;
   localparam int STEP_W    = $clog2(PROD_W);
   localparam int CAP_BIT   = 40;
   localparam int TERM_W    = CAP_BIT + 2;
   localparam int VAL_W     = TERM_W + 1;
   localparam int ENTRY_W   = 2 * DATA_W;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic CSR_KNOT_COUNT = 1'b0;
   localparam logic CSR_EXTRAP_EN  = 1'b1;

   localparam logic [1:0] REGION_INNER = 2'd0;
   localparam logic [1:0] REGION_BELOW = 2'd1;
   localparam logic [1:0] REGION_ABOVE = 2'd2;
   localparam logic [1:0] REGION_EXACT = 2'd3;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] t;
   } scale_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [TERM_W-1:0] term;
   } scale_rsp_type;

   function automatic logic signed [DIFF_W-1:0] diff33(input logic [DATA_W-1:0] a,
                                                      input logic [DATA_W-1:0] b);
      diff33 = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
   endfunction

   function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
      mag33 = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
   endfunction

endpackage

// ===== rtl/pli_knot_ram.sv =====
// Knot table memory: one write port, one registered read port, {x, y} per entry.
`timescale 1ns / 1ps

module pli_knot_ram
   import pli_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem [MAX_KNOTS];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/pli_scale_unit.sv =====
// Multi-cycle unit computing trunc(dy * t / dx) with the quotient capped at 2^40.
`timescale 1ns / 1ps

module pli_scale_unit
   import pli_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  scale_req_type req,
   output scale_rsp_type rsp
);

   typedef enum logic [4:0] {
      U_IDLE = 5'b00001,
      U_MUL0 = 5'b00010,
      U_MUL1 = 5'b00100,
      U_DIV  = 5'b01000,
      U_FIN  = 5'b10000
   } ustate_type;

   ustate_type         state_ff, state_in;
   logic [DIFF_W-1:0]  a_ff, a_in, b_ff, b_in, d_ff, d_in;
   logic               neg_ff, neg_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DIFF_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;

   logic [DIFF_W+HALF_W-1:0]   pp_lo;
   logic [PROD_W-HALF_W-1:0]   pp_hi;
   logic [DIFF_W:0]            rem_sh;
   logic                       ge;
   logic                       over;
   logic [CAP_BIT:0]           cap;

   assign pp_lo  = a_ff * b_ff[HALF_W-1:0];
   assign pp_hi  = (PROD_W-HALF_W)'(a_ff * b_ff[DIFF_W-1:HALF_W]);
   assign rem_sh = {rem_ff, prod_ff[PROD_W-1]};
   assign ge     = rem_sh >= {1'b0, d_ff};

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      d_in     = d_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               a_in     = mag33(req.dy);
               b_in     = mag33(req.t);
               d_in     = req.dx;
               neg_in   = req.dy[DIFF_W-1] ^ req.t[DIFF_W-1];
               state_in = U_MUL0;
            end
         end
         U_MUL0: begin
            prod_in  = PROD_W'(pp_lo);
            state_in = U_MUL1;
         end
         U_MUL1: begin
            prod_in  = prod_ff + {pp_hi, {HALF_W{1'b0}}};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = U_DIV;
         end
         U_DIV: begin
            // Restoring division, one quotient bit per cycle shifted into prod.
            rem_in  = ge ? DIFF_W'(rem_sh - {1'b0, d_ff}) : rem_sh[DIFF_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], ge};
            cnt_in  = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(PROD_W - 1)) begin
               state_in = U_FIN;
            end
         end
         U_FIN: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      d_ff    <= d_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign over = (prod_ff[PROD_W-1:CAP_BIT+1] != '0) ||
                 (prod_ff[CAP_BIT] && (prod_ff[CAP_BIT-1:0] != '0));
   assign cap  = over ? {1'b1, {CAP_BIT{1'b0}}} : prod_ff[CAP_BIT:0];

   assign rsp.done = (state_ff == U_FIN);
   assign rsp.term = neg_ff ? -$signed({1'b0, cap}) : $signed({1'b0, cap});

endmodule

// ===== rtl/piecewise_linear_interpolator.sv =====
// Top level: control sequencer, configuration registers and result register.
//
// Usage. Items arrive on the req_ channel (valid/stall); cmd 0 writes knot
// (knot_x, knot_y) at knot_index, cmd 1 queries the curve at query_x. Each query
// gives one beat on the rsp_ channel with interp_y, region and saturated;
// writes give none. knot_count and extrapolate_enable sit behind the csr_
// APB port at byte addresses 0 and 4; the user must write them only while the
// block is idle, since the block itself does not enforce it. A write leaves
// the sequencer idle, so the next item can follow it. A query reads the table
// through its single registered read port: it fetches the end knots and
// classifies the query, then scans the knots one at a time, and when a segment
// must be evaluated the scale unit runs two multiply steps, 66 division steps
// and a finish step. req_stall is high while a query is in work. The result
// register lets the next item be accepted while a result beat waits; if the
// receiver keeps rsp_stall high, a finished query holds in the sequencer until
// the register frees up. Reset (synchronous) empties the result register and
// returns knot_count to 2 and extrapolate_enable to 0; the table is left as is
// and must be written before it is queried.
`timescale 1ns / 1ps

module piecewise_linear_interpolator
   import pli_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_cmd,
   input  logic [IDX_W-1:0]         req_knot_index,
   input  logic signed [DATA_W-1:0] req_knot_x,
   input  logic signed [DATA_W-1:0] req_knot_y,
   input  logic signed [DATA_W-1:0] req_query_x,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_interp_y,
   output logic [1:0]               rsp_region,
   output logic                     rsp_saturated,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_AW-1:0]        csr_paddr,
   input  logic [CSR_DW-1:0]        csr_pwdata,
   output logic [CSR_DW-1:0]        csr_prdata,
   output logic                     csr_pready
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_RD_LAST = 8'b0000_0010,
      S_CLASS   = 8'b0000_0100,
      S_SCAN    = 8'b0000_1000,
      S_SEG_LO  = 8'b0001_0000,
      S_SEG_HI  = 8'b0010_0000,
      S_CALC    = 8'b0100_0000,
      S_DONE    = 8'b1000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                extrap_ff, extrap_in;
   logic [IDX_W-1:0]    last_ff, last_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [DATA_W-1:0]   q_ff, q_in;
   logic [DATA_W-1:0]   lo_x_ff, lo_x_in, lo_y_ff, lo_y_in;
   logic [DATA_W-1:0]   hi_x_ff, hi_x_in, hi_y_ff, hi_y_in;
   logic [DATA_W-1:0]   ay_ff, ay_in;
   logic [1:0]          region_ff, region_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_y_ff, rsp_y_in;
   logic [1:0]          rsp_region_ff, rsp_region_in;
   logic                rsp_sat_ff, rsp_sat_in;

   logic                req_accept, csr_write, load_rsp, sat;
   logic [IDX_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   logic [DATA_W-1:0]   rd_x, rd_y;
   logic signed [DIFF_W-1:0] seg_dx, seg_dy, seg_t;
   logic [DATA_W-1:0]   seg_ay;
   logic                seg_go;
   scale_req_type       scale_req;
   scale_rsp_type       scale_rsp;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   pli_knot_ram u_ram (
      .clock   (clock),
      .wr_en   (req_accept && (req_cmd == CMD_WRITE)),
      .wr_addr (req_knot_index),
      .wr_data ({req_knot_x, req_knot_y}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_x = rd_data[ENTRY_W-1:DATA_W];
   assign rd_y = rd_data[DATA_W-1:0];

   pli_scale_unit u_scale (
      .clock (clock),
      .reset (reset),
      .req   (scale_req),
      .rsp   (scale_rsp)
   );

   // Segment operands; the upper end segment is anchored at the last knot.
   always_comb begin
      if (state_ff == S_SEG_HI) begin
         seg_dx = diff33(hi_x_ff, rd_x);
         seg_dy = diff33(hi_y_ff, rd_y);
         seg_t  = diff33(q_ff, hi_x_ff);
         seg_ay = hi_y_ff;
      end else begin
         seg_dx = diff33(rd_x, lo_x_ff);
         seg_dy = diff33(rd_y, lo_y_ff);
         seg_t  = diff33(q_ff, lo_x_ff);
         seg_ay = lo_y_ff;
      end
   end

   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      last_in         = last_ff;
      idx_in          = idx_ff;
      q_in            = q_ff;
      lo_x_in         = lo_x_ff;
      lo_y_in         = lo_y_ff;
      hi_x_in         = hi_x_ff;
      hi_y_in         = hi_y_ff;
      ay_in           = ay_ff;
      region_in       = region_ff;
      val_in          = val_ff;
      rd_addr         = '0;
      seg_go          = 1'b0;
      scale_req.start = 1'b0;
      scale_req.dx    = seg_dx;
      scale_req.dy    = seg_dy;
      scale_req.t     = seg_t;
      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_cmd == CMD_QUERY)) begin
               q_in = req_query_x;
               if (count_ff < CNT_W'(2)) begin
                  last_in = IDX_W'(1);
               end else if (count_ff >= CNT_W'(MAX_KNOTS)) begin
                  last_in = IDX_W'(MAX_KNOTS - 1);
               end else begin
                  last_in = IDX_W'(count_ff - CNT_W'(1));
               end
               state_in = S_RD_LAST;
            end
         end
         S_RD_LAST: begin
            lo_x_in  = rd_x;
            lo_y_in  = rd_y;
            rd_addr  = last_ff;
            state_in = S_CLASS;
         end
         S_CLASS: begin
            hi_x_in = rd_x;
            hi_y_in = rd_y;
            if ($signed(q_ff) < $signed(lo_x_ff)) begin
               region_in = REGION_BELOW;
               rd_addr   = IDX_W'(1);
               if (extrap_ff) begin
                  state_in = S_SEG_LO;
               end else begin
                  val_in   = VAL_W'($signed(lo_y_ff));
                  state_in = S_DONE;
               end
            end else if ($signed(q_ff) > $signed(rd_x)) begin
               region_in = REGION_ABOVE;
               rd_addr   = last_ff - IDX_W'(1);
               if (extrap_ff) begin
                  state_in = S_SEG_HI;
               end else begin
                  val_in   = VAL_W'($signed(rd_y));
                  state_in = S_DONE;
               end
            end else if (q_ff == lo_x_ff) begin
               region_in = REGION_EXACT;
               val_in    = VAL_W'($signed(lo_y_ff));
               state_in  = S_DONE;
            end else begin
               region_in = REGION_INNER;
               rd_addr   = IDX_W'(1);
               idx_in    = IDX_W'(1);
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            // The held knot was already tested for an exact hit, so the
            // segment ending here is tested before this knot itself.
            rd_addr = idx_ff + IDX_W'(1);
            if (($signed(lo_x_ff) < $signed(q_ff)) && ($signed(rd_x) > $signed(q_ff))) begin
               seg_go = 1'b1;
            end else if (rd_x == q_ff) begin
               region_in = REGION_EXACT;
               val_in    = VAL_W'($signed(rd_y));
               state_in  = S_DONE;
            end else if (idx_ff == last_ff) begin
               val_in   = '0;
               state_in = S_DONE;
            end else begin
               lo_x_in = rd_x;
               lo_y_in = rd_y;
               idx_in  = idx_ff + IDX_W'(1);
            end
         end
         S_SEG_LO, S_SEG_HI: begin
            seg_go = 1'b1;
         end
         S_CALC: begin
            if (scale_rsp.done) begin
               val_in   = VAL_W'($signed(ay_ff)) + VAL_W'(scale_rsp.term);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (seg_go) begin
         ay_in = seg_ay;
         if (!seg_dx[DIFF_W-1] && (seg_dx != '0)) begin
            scale_req.start = 1'b1;
            state_in        = S_CALC;
         end else begin
            val_in   = VAL_W'($signed(seg_ay));
            state_in = S_DONE;
         end
      end
   end

   assign sat = (val_ff[VAL_W-1:DATA_W-1] != '0) && (val_ff[VAL_W-1:DATA_W-1] != '1);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_y_in      = rsp_y_ff;
      rsp_region_in = rsp_region_ff;
      rsp_sat_in    = rsp_sat_ff;
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_region_in = region_ff;
         rsp_sat_in    = sat;
         if (!sat) begin
            rsp_y_in = val_ff[DATA_W-1:0];
         end else if (val_ff[VAL_W-1]) begin
            rsp_y_in = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            rsp_y_in = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      extrap_in = extrap_ff;
      if (csr_write) begin
         if (csr_paddr[2] == CSR_KNOT_COUNT) begin
            count_in = csr_pwdata[CNT_W-1:0];
         end else begin
            extrap_in = csr_pwdata[0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_EXTRAP_EN) ? CSR_DW'(extrap_ff) :
                                                         CSR_DW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(2);
         extrap_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         extrap_ff    <= extrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff       <= last_in;
      idx_ff        <= idx_in;
      q_ff          <= q_in;
      lo_x_ff       <= lo_x_in;
      lo_y_ff       <= lo_y_in;
      hi_x_ff       <= hi_x_in;
      hi_y_ff       <= hi_y_in;
      ay_ff         <= ay_in;
      region_ff     <= region_in;
      val_ff        <= val_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_region_ff <= rsp_region_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_interp_y  = rsp_y_ff;
   assign rsp_region    = rsp_region_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      scale_rsp.done |-> (state_ff == S_CALC))
      else $error("scale unit finished outside of a segment evaluation");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (idx_ff <= last_ff) && (idx_ff != '0))
      else $error("knot scan ran past the last valid knot");

   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_cmd == CMD_QUERY)) |=> (state_ff == S_RD_LAST))
      else $error("accepted query did not start the table read");

   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid && (state_ff == S_IDLE))
      else $error("finished query did not reach the result register");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the piecewise linear interpolator: directed rows, then random traffic.
`timescale 1ns / 1ps

module tb;
   import pli_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 120;
   localparam logic [CSR_AW-1:0] ADDR_KNOT_COUNT = CSR_AW'(4 * CSR_KNOT_COUNT);
   localparam logic [CSR_AW-1:0] ADDR_EXTRAP_EN  = CSR_AW'(4 * CSR_EXTRAP_EN);

   typedef struct {
      logic              cmd;
      logic [IDX_W-1:0]  idx;
      logic [31:0]       kx;
      logic [31:0]       ky;
      logic [31:0]       qx;
      bit                typed;
      logic [31:0]       ey;
      logic [1:0]        ereg;
      logic              esat;
   } item_type;

   typedef struct {
      logic [31:0] y;
      logic [1:0]  region;
      logic        sat;
   } answer_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_cmd = 0;
   logic [IDX_W-1:0] req_knot_index = '0;
   logic signed [DATA_W-1:0] req_knot_x = '0, req_knot_y = '0, req_query_x = '0;
   logic req_stall, rsp_valid, rsp_saturated, csr_pready;
   logic rsp_stall = 1;
   logic signed [DATA_W-1:0] rsp_interp_y;
   logic [1:0] rsp_region;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0, csr_prdata;

   piecewise_linear_interpolator u_top (.*);

   logic signed [31:0] knot_x_mem [MAX_KNOTS];
   logic signed [31:0] knot_y_mem [MAX_KNOTS];
   logic [4:0] cfg_count = 5'd2;
   logic       cfg_extrap = 1'b0;
   answer_type answers_due [$];
   int errors = 0, cycles = 0;
   int rsp_pause = 0, long_hold = 0;
   bit quiet = 0, typed_now = 0;
   answer_type typed_answer;
   item_type stim [$];

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report(string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   function automatic int eff_count();
      int n = cfg_count;
      if (n < 2) n = 2;
      if (n > MAX_KNOTS) n = MAX_KNOTS;
      return n;
   endfunction

   // trunc(dy * t / dx) with the quotient magnitude capped at 2^40.
   function automatic longint slope_term(longint dy, longint t, longint dx);
      logic [127:0] a, b, q;
      bit neg;
      neg = (dy < 0) != (t < 0);
      a = 128'(dy < 0 ? -dy : dy);
      b = 128'(t < 0 ? -t : t);
      q = (a * b) / 128'(dx);
      if (q > (128'd1 << CAP_BIT)) q = 128'd1 << CAP_BIT;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint segment_at(int lo, int hi, int anchor, longint q);
      longint dx, dy;
      dx = longint'(knot_x_mem[hi]) - longint'(knot_x_mem[lo]);
      dy = longint'(knot_y_mem[hi]) - longint'(knot_y_mem[lo]);
      if (dx <= 0) return longint'(knot_y_mem[anchor]);
      return longint'(knot_y_mem[anchor])
             + slope_term(dy, q - longint'(knot_x_mem[anchor]), dx);
   endfunction

   function automatic answer_type eval_curve(logic signed [31:0] qx);
      answer_type r;
      int n;
      longint q, v;
      n = eff_count();
      q = qx;
      v = 0;
      r.region = REGION_INNER;
      r.sat = 0;
      if (q < knot_x_mem[0]) begin
         r.region = REGION_BELOW;
         v = cfg_extrap ? segment_at(0, 1, 0, q) : longint'(knot_y_mem[0]);
      end else if (q > knot_x_mem[n-1]) begin
         r.region = REGION_ABOVE;
         v = cfg_extrap ? segment_at(n-2, n-1, n-1, q) : longint'(knot_y_mem[n-1]);
      end else begin
         for (int i = 0; i < n; i++) begin
            if (knot_x_mem[i] == qx) begin
               r.region = REGION_EXACT;
               v = knot_y_mem[i];
               break;
            end
            if (i + 1 < n && knot_x_mem[i] < qx && knot_x_mem[i+1] > qx) begin
               v = segment_at(i, i + 1, i, q);
               break;
            end
         end
      end
      if (v > 64'sd2147483647) begin
         v = 64'sd2147483647;
         r.sat = 1;
      end else if (v < -64'sd2147483648) begin
         v = -64'sd2147483648;
         r.sat = 1;
      end
      r.y = v[31:0];
      return r;
   endfunction

   // Input monitor: updates the table copy and queues the answer of each query.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (req_cmd == CMD_WRITE) begin
            knot_x_mem[req_knot_index] <= req_knot_x;
            knot_y_mem[req_knot_index] <= req_knot_y;
         end else begin
            answers_due = {answers_due,
                           (typed_now ? typed_answer : eval_curve(req_query_x))};
         end
      end
   end

   // Output monitor.
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report("result beat with nothing expected");
         end else begin
            e = answers_due.pop_front();
            if (rsp_interp_y !== e.y)
               report($sformatf("interp_y %h, expected %h", rsp_interp_y, e.y));
            if (rsp_region !== e.region)
               report($sformatf("region %0d, expected %0d", rsp_region, e.region));
            if (rsp_saturated !== e.sat)
               report($sformatf("saturated %b, expected %b", rsp_saturated, e.sat));
         end
         rsp_pause = quiet ? 0 : $urandom_range(0, 3);
      end
   end

   // Receiver stall generator; a long hold overrides the per-beat pause.
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_stall = 1;
            long_hold--;
         end else if (rsp_pause > 0) begin
            rsp_stall = 1;
            rsp_pause--;
         end else begin
            rsp_stall = 0;
         end
      end
   end

   task automatic send(item_type it);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 0;
      end
      @(negedge clock);
      req_cmd = it.cmd;
      req_knot_index = it.idx;
      req_knot_x = it.kx;
      req_knot_y = it.ky;
      req_query_x = it.qx;
      typed_now = it.typed;
      typed_answer = '{it.ey, it.ereg, it.esat};
      req_valid = 1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] data);
      @(negedge clock);
      csr_psel = 1;
      csr_pwrite = 1;
      csr_penable = 0;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_KNOT_COUNT) cfg_count = data[4:0];
      else cfg_extrap = data[0];
      @(negedge clock);
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic item_type knot_write(int idx, logic [31:0] x, logic [31:0] y);
      item_type it = '{default: '0};
      it.cmd = CMD_WRITE;
      it.idx = IDX_W'(idx);
      it.kx = x;
      it.ky = y;
      it.qx = $urandom();
      return it;
   endfunction

   function automatic item_type query(logic [31:0] x);
      item_type it = '{default: '0};
      it.cmd = CMD_QUERY;
      it.idx = IDX_W'($urandom());
      it.kx = $urandom();
      it.ky = $urandom();
      it.qx = x;
      return it;
   endfunction

   // Queues a fresh increasing table into all sixteen slots.
   task automatic queue_table();
      longint xs [$];
      longint base, step;
      logic [31:0] y;
      if ($urandom_range(0, 1)) begin
         repeat (MAX_KNOTS) xs = {xs, longint'($signed($urandom()))};
         xs.sort();
      end else begin
         base = longint'($signed($urandom())) >>> $urandom_range(0, 8);
         for (int i = 0; i < MAX_KNOTS; i++) begin
            step = $urandom_range(1, 32'h40000);
            base = base + step;
            if (base > 64'sd2147483647) base = 64'sd2147483647 - MAX_KNOTS + i;
            xs = {xs, base};
         end
      end
      for (int i = 0; i < MAX_KNOTS; i++) begin
         y = $urandom_range(0, 1) ? $urandom() : 32'($signed($urandom_range(0, 32'h80000))
                                                     - 32'sh40000);
         stim = {stim, knot_write(i, xs[i][31:0], y)};
      end
   endtask

   function automatic logic [31:0] pick_query();
      int n, i;
      longint a, b;
      n = eff_count();
      i = $urandom_range(0, n - 1);
      case ($urandom_range(0, 5))
         0: return knot_x_mem[i];
         1: return knot_x_mem[n-1];
         2: begin
            a = knot_x_mem[i];
            b = knot_x_mem[(i + 1 < n) ? i + 1 : i];
            return 32'(a + (b - a) * $urandom_range(0, 255) / 256);
         end
         3: begin
            a = longint'(knot_x_mem[0]) - $urandom_range(1, 32'h7FFFFFFF);
            return (a < -64'sd2147483648) ? 32'h8000_0000 : a[31:0];
         end
         4: begin
            a = longint'(knot_x_mem[n-1]) + $urandom_range(1, 32'h7FFFFFFF);
            return (a > 64'sd2147483647) ? 32'h7FFF_FFFF : a[31:0];
         end
         default: return $urandom();
      endcase
   endfunction

   task automatic random_batch(int count);
      item_type it;
      for (int k = 0; k < count; k++) begin
         if (stim.size() == 0) begin
            if ($urandom_range(0, 24) == 0) queue_table();
            else if ($urandom_range(0, 9) < 2)
               stim = {stim, knot_write($urandom_range(0, MAX_KNOTS - 1),
                                        $urandom(), $urandom())};
            else stim = {stim, query(32'h0)};
         end
         it = stim.pop_front();
         // Query points are chosen against the table as it stands when sent.
         if (it.cmd == CMD_QUERY) it.qx = pick_query();
         send(it);
      end
   endtask

   item_type directed [$];
   logic [5:0] phase_set [8] = '{6'h02, 6'h21, 6'h01, 6'h3F, 6'h0A, 6'h20, 6'h11, 6'h30};

   initial begin
      item_type it;
      // Table: extremes at both ends, whole steps in between.
      for (int i = 0; i < MAX_KNOTS; i++) begin
         if (i == 0) directed = {directed, knot_write(i, 32'h8000_0000, 32'h7FFF_FFFF)};
         else if (i == MAX_KNOTS - 1)
            directed = {directed, knot_write(i, 32'h7FFF_FFFF, 32'h8000_0000)};
         else directed = {directed, knot_write(i, 32'((i - 8) << 16), 32'(i << 16))};
      end
      // After reset two knots are live and the ends clamp.
      it = query(32'h8000_0000);
      it.typed = 1; it.ey = 32'h7FFF_FFFF; it.ereg = REGION_EXACT; it.esat = 0;
      directed = {directed, it};
      it = query(32'h0);
      it.typed = 1; it.ey = 32'h0001_0000; it.ereg = REGION_ABOVE; it.esat = 0;
      directed = {directed, it};
      it = query(32'h7FFF_FFFF);
      it.typed = 1; it.ey = 32'h0001_0000; it.ereg = REGION_ABOVE; it.esat = 0;
      directed = {directed, it};
      directed = {directed, query(32'h8000_0001)};
      directed = {directed, query(32'hFFF9_0000)};
      directed = {directed, query(32'hC000_0000)};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed[r]) send(directed[r]);
      random_batch(40);

      for (int p = 0; p < 8; p++) begin
         settle();
         csr_write(ADDR_KNOT_COUNT, {27'b0, phase_set[p][4:0]});
         csr_write(ADDR_EXTRAP_EN, {31'b0, phase_set[p][5]});
         quiet = (p == 2);
         if (p == 4) long_hold = 400;
         random_batch(55);
      end

      settle();
      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/pli_pkg.sv
rtl/pli_knot_ram.sv
rtl/pli_scale_unit.sv
rtl/piecewise_linear_interpolator.sv
bench/tb.sv
